// ----- hw/rtl/mnemonic_opcode_hash_table_assert.svh -----
// Assertion macros for the mnemonic opcode hash table checker.
// Each macro expects clk_i and rst_ni in scope; no other dependencies.
`ifndef MNEMONIC_OPCODE_HASH_TABLE_ASSERT_SVH
`define MNEMONIC_OPCODE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MOHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("moht: check failed");

// Next-cycle implication, checked out of reset
`define MOHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("moht: check failed");

`endif

// ----- hw/rtl/moht_pkg.sv -----
// Shared constants, codes and helper functions of the mnemonic opcode hash table.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package moht_pkg;

  // Table geometry
  localparam int NumBuckets = 20;
  localparam int BucketWays = 4;
  localparam int KeyChars   = 8;

  // djb2: hash*33 + char, i.e. five doublings plus the old value
  localparam int HashSeed  = 5381;
  localparam int ShiftBits = 5;
  localparam int SeedRes   = HashSeed % NumBuckets;

  localparam int KeyW   = 64;
  localparam int CodeW  = 8;
  localparam int StatW  = 3;
  localparam int BktOutW = 5;
  localparam int BktW   = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int Depth  = NumBuckets * BucketWays;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW  = $clog2(BucketWays + 1);

  // Command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // Status codes
  localparam logic [StatW-1:0] StInserted  = 3'd0;
  localparam logic [StatW-1:0] StDuplicate = 3'd1;
  localparam logic [StatW-1:0] StFull      = 3'd2;
  localparam logic [StatW-1:0] StHit       = 3'd3;
  localparam logic [StatW-1:0] StMiss      = 3'd4;

  // Reduce a value below twice the bucket count
  function automatic logic [BktW-1:0] mod_two(input logic [BktW:0] x);
    logic [BktW:0] n;
    n = (BktW + 1)'(NumBuckets);
    if (x >= n) mod_two = BktW'(x - n);
    else        mod_two = BktW'(x);
  endfunction

  // Sum three residues and reduce below the bucket count
  function automatic logic [BktW-1:0] mod_sum3(input logic [BktW-1:0] a,
                                               input logic [BktW-1:0] b,
                                               input logic [BktW-1:0] c);
    logic [BktW+1:0] s;
    logic [BktW+1:0] n;
    logic [BktW+1:0] n2;
    s  = {2'b00, a} + {2'b00, b} + {2'b00, c};
    n  = (BktW + 2)'(NumBuckets);
    n2 = (BktW + 2)'(2 * NumBuckets);
    if (s >= n2)     mod_sum3 = BktW'(s - n2);
    else if (s >= n) mod_sum3 = BktW'(s - n);
    else             mod_sum3 = BktW'(s);
  endfunction

  // Drop bytes from the first NUL on and bytes beyond the key length
  function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] raw);
    logic            seen;
    logic [7:0]      ch;
    logic [KeyW-1:0] k;
    seen = 1'b0;
    k    = '0;
    for (int i = 0; i < 8; i++) begin
      ch = raw[KeyW-1-8*i -: 8];
      if (ch == 8'h00 || i >= KeyChars) seen = 1'b1;
      if (!seen) k[KeyW-1-8*i -: 8] = ch;
    end
    norm_key = k;
  endfunction

endpackage

// ----- hw/rtl/mnemonic_opcode_hash_table.sv -----
// Top level of the mnemonic opcode hash table: bit-serial djb2 hash, bucket search, insert.
// Depends on moht_pkg; checker attaches by bind from moht_checker.sv.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy then stays high until the
// result is shown. The mnemonic is hashed one bit per cycle up to the first NUL, and a
// final step closes the hash. The bucket is then searched one way at a time through the
// single read port of the entry memory, with a read state and a compare state per
// occupied way, stopping at the first match. The final state, SFin, registers the result
// and writes the entry on an insert, and the result shows in the cycle after it. The
// result shows for one cycle on result_valid_o and cannot be held off; the next command
// may be taken in that same cycle. No clearing pass runs after reset: only the per-bucket
// fill counts reset, and no entry is read above its bucket's fill count.
module mnemonic_opcode_hash_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic [moht_pkg::KeyW-1:0]         mnemonic_i,
  input  logic [moht_pkg::CodeW-1:0]        opcode_in_i,
  output logic                              result_valid_o,
  output logic [moht_pkg::StatW-1:0]        status_o,
  output logic [moht_pkg::CodeW-1:0]        opcode_out_o,
  output logic [moht_pkg::BktOutW-1:0]      bucket_o
);

  localparam int BktW  = moht_pkg::BktW;
  localparam int AddrW = moht_pkg::AddrW;
  localparam int FillW = moht_pkg::FillW;
  localparam int KeyW  = moht_pkg::KeyW;
  localparam int CodeW = moht_pkg::CodeW;

  // State codes
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SHash = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SCmp  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              cmd_q;
  logic [CodeW-1:0]  code_in_q;
  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   sr_q;
  logic [2:0]        bit_q;
  logic [BktW-1:0]   r_q, a_q, b_q;
  logic [AddrW-1:0]  base_q;
  logic [FillW-1:0]  fillc_q;
  logic [FillW-1:0]  wy_q;
  logic              found_q;
  logic [CodeW-1:0]  code_q;
  logic [FillW-1:0]  fill_q [moht_pkg::NumBuckets];

  logic              res_vld_q;
  logic [moht_pkg::StatW-1:0] status_q;
  logic [CodeW-1:0]  opc_out_q;

  // Entry memory: key in the upper bits, opcode in the low byte
  logic [KeyW+CodeW-1:0] mem [moht_pkg::Depth];
  logic [KeyW+CodeW-1:0] rd_q;

  logic              nul_hit;
  logic [BktW-1:0]   a_base, b_base, a_nx, b_nx, r_nx;
  logic [AddrW-1:0]  rd_addr, wr_addr, base_nx;
  logic              can_store;
  logic              key_match;
  logic [31:0]       bkt_wide;

  // Hash datapath: one key bit per cycle
  always_comb begin
    nul_hit = (bit_q == 3'd0) && (sr_q[KeyW-1 -: 8] == 8'h00);
    a_base  = (bit_q == 3'd0) ? '0 : a_q;
    b_base  = (bit_q == 3'd0) ? r_q : b_q;
    a_nx    = moht_pkg::mod_two({a_base, sr_q[KeyW-1]});
    b_nx    = (32'(bit_q) < moht_pkg::ShiftBits) ? moht_pkg::mod_two({b_base, 1'b0}) : b_base;
    r_nx    = moht_pkg::mod_sum3(b_nx, r_q, a_nx);
  end

  // Bucket addressing and search decisions
  always_comb begin
    base_nx   = AddrW'(32'(r_q) * moht_pkg::BucketWays);
    rd_addr   = base_q + AddrW'(wy_q);
    wr_addr   = base_q + AddrW'(fillc_q);
    can_store = (cmd_q == moht_pkg::CmdInsert) && !found_q &&
                (32'(fillc_q) < moht_pkg::BucketWays);
    key_match = (rd_q[KeyW+CodeW-1:CodeW] == key_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (start) state_d = SHash;
      SHash: begin
        if (nul_hit) begin
          state_d = (fill_q[r_q] == '0) ? SFin : SRead;
        end
      end
      SRead: state_d = SCmp;
      SCmp: begin
        if (key_match || (wy_q + FillW'(1) == fillc_q)) state_d = SFin;
        else state_d = SRead;
      end
      SFin:    state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cmd_q     <= moht_pkg::CmdInsert;
      code_in_q <= '0;
      key_q     <= '0;
      sr_q      <= '0;
      bit_q     <= '0;
      r_q       <= '0;
      a_q       <= '0;
      b_q       <= '0;
      base_q    <= '0;
      fillc_q   <= '0;
      wy_q      <= '0;
      found_q   <= 1'b0;
      code_q    <= '0;
      res_vld_q <= 1'b0;
      for (int i = 0; i < moht_pkg::NumBuckets; i++) fill_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= (state_q == SFin);
      case (state_q)
        SIdle: begin
          if (start) begin
            cmd_q     <= cmd_i;
            code_in_q <= opcode_in_i;
            key_q     <= moht_pkg::norm_key(mnemonic_i);
            sr_q      <= moht_pkg::norm_key(mnemonic_i);
            bit_q     <= '0;
            r_q       <= BktW'(moht_pkg::SeedRes);
          end
        end
        SHash: begin
          if (nul_hit) begin
            // Hash closed: latch bucket base and fill, start the search
            base_q  <= base_nx;
            fillc_q <= fill_q[r_q];
            wy_q    <= '0;
            found_q <= 1'b0;
          end else begin
            sr_q  <= {sr_q[KeyW-2:0], 1'b0};
            a_q   <= a_nx;
            b_q   <= b_nx;
            bit_q <= bit_q + 3'd1;
            if (bit_q == 3'd7) r_q <= r_nx;
          end
        end
        SRead: ;
        SCmp: begin
          if (key_match) begin
            found_q <= 1'b1;
            code_q  <= rd_q[CodeW-1:0];
          end else begin
            wy_q <= wy_q + FillW'(1);
          end
        end
        SFin: begin
          if (can_store) fill_q[r_q] <= fillc_q + FillW'(1);
        end
        default: ;
      endcase
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (state_q == SFin) begin
      opc_out_q <= '0;
      if (cmd_q == moht_pkg::CmdInsert) begin
        if (found_q)        status_q <= moht_pkg::StDuplicate;
        else if (can_store) status_q <= moht_pkg::StInserted;
        else                status_q <= moht_pkg::StFull;
      end else if (found_q) begin
        status_q  <= moht_pkg::StHit;
        opc_out_q <= code_q;
      end else begin
        status_q <= moht_pkg::StMiss;
      end
    end
  end

  // Entry memory: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == SFin && can_store) mem[wr_addr] <= {key_q, code_in_q};
    rd_q <= mem[rd_addr];
  end

  assign bkt_wide       = 32'(r_q);
  assign busy           = (state_q != SIdle);
  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign opcode_out_o   = opc_out_q;
  assign bucket_o       = bkt_wide[moht_pkg::BktOutW-1:0];

endmodule

// ----- hw/rtl/moht_checker.sv -----
// Port-level checker for the mnemonic opcode hash table, bound to the top level.
// Depends on moht_pkg and mnemonic_opcode_hash_table_assert.svh.
`timescale 1ns / 1ps
`include "mnemonic_opcode_hash_table_assert.svh"

module moht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic [moht_pkg::StatW-1:0]    status_o,
  input logic [moht_pkg::CodeW-1:0]    opcode_out_o
);

  // A taken command holds the block busy
  `MOHT_ASSERT_NEXT(a_start_busy, start && !busy, busy)

  // A result only closes work that was in flight
  `MOHT_ASSERT_NOW(a_res_after_busy, result_valid_o, $past(busy) && !busy)

  // Status is one of the defined codes
  `MOHT_ASSERT_NOW(a_status_code, result_valid_o,
    status_o == moht_pkg::StInserted || status_o == moht_pkg::StDuplicate ||
    status_o == moht_pkg::StFull || status_o == moht_pkg::StHit ||
    status_o == moht_pkg::StMiss)

  // Opcode is zero on anything but a hit
  `MOHT_ASSERT_NOW(a_opcode_zero, result_valid_o && status_o != moht_pkg::StHit,
    opcode_out_o == '0)

endmodule

bind mnemonic_opcode_hash_table moht_checker u_moht_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the mnemonic opcode hash table: insert and lookup items.
// It depends on moht_pkg and the mnemonic_opcode_hash_table top level, and nothing else.
`timescale 1ns / 1ps

module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 100;
  localparam int DjbMult       = 33;

  typedef struct packed {
    logic                       cmd;
    logic [moht_pkg::KeyW-1:0]  mnem;
    logic [moht_pkg::CodeW-1:0] code;
  } req_t;

  typedef struct packed {
    logic [moht_pkg::StatW-1:0]   status;
    logic [moht_pkg::CodeW-1:0]   code;
    logic [moht_pkg::BktOutW-1:0] bkt;
  } resp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t drv_req = '0;
  logic                         result_valid_o;
  logic [moht_pkg::StatW-1:0]   status_o;
  logic [moht_pkg::CodeW-1:0]   opcode_out_o;
  logic [moht_pkg::BktOutW-1:0] bucket_o;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  logic [moht_pkg::KeyW-1:0] key_pool[$];

  // Shadow copy of the table
  logic [moht_pkg::KeyW-1:0]  tbl_keys [moht_pkg::Depth];
  logic [moht_pkg::CodeW-1:0] tbl_codes[moht_pkg::Depth];
  int                         tbl_fill [moht_pkg::NumBuckets];

  bit item_taken    = 1'b0;
  int send_idle_pct = 0;
  int fail_count    = 0;
  int items_taken   = 0;
  int idle_cycles   = 0;
  int status_tally[8];

  mnemonic_opcode_hash_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (drv_req.cmd),
    .mnemonic_i     (drv_req.mnem),
    .opcode_in_i    (drv_req.code),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .opcode_out_o   (opcode_out_o),
    .bucket_o       (bucket_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // Hash the mnemonic up to its first NUL, then apply the command to the shadow table
  function automatic resp_t apply_request(req_t rq);
    logic [moht_pkg::KeyW-1:0] key;
    logic [63:0]               h;
    logic [7:0]                ch;
    logic                      at_end;
    int                        bkt;
    int                        hit_slot;
    int                        slot;
    resp_t                     rs;
    key    = '0;
    h      = 64'(moht_pkg::HashSeed);
    at_end = 1'b0;
    for (int i = 0; i < moht_pkg::KeyChars; i++) begin
      ch = rq.mnem[moht_pkg::KeyW-1-8*i -: 8];
      if (ch == 8'h00) at_end = 1'b1;
      if (!at_end) begin
        key[moht_pkg::KeyW-1-8*i -: 8] = ch;
        h = h * DjbMult + 64'(ch);
      end
    end
    bkt      = int'(h % 64'(moht_pkg::NumBuckets));
    hit_slot = -1;
    for (int w = 0; w < tbl_fill[bkt]; w++) begin
      slot = bkt * moht_pkg::BucketWays + w;
      if (hit_slot < 0 && tbl_keys[slot] == key) hit_slot = slot;
    end
    rs.code = '0;
    rs.bkt  = moht_pkg::BktOutW'(bkt);
    if (rq.cmd == moht_pkg::CmdInsert) begin
      if (hit_slot >= 0) begin
        rs.status = moht_pkg::StDuplicate;
      end else if (tbl_fill[bkt] >= moht_pkg::BucketWays) begin
        rs.status = moht_pkg::StFull;
      end else begin
        slot            = bkt * moht_pkg::BucketWays + tbl_fill[bkt];
        tbl_keys[slot]  = key;
        tbl_codes[slot] = rq.code;
        tbl_fill[bkt]++;
        rs.status = moht_pkg::StInserted;
      end
    end else if (hit_slot >= 0) begin
      rs.status = moht_pkg::StHit;
      rs.code   = tbl_codes[hit_slot];
    end else begin
      rs.status = moht_pkg::StMiss;
    end
    return rs;
  endfunction

  // Driver: advance to the next item once the current one is taken, idling at random
  always @(negedge clk_i) begin
    if (rst_ni && (item_taken || !start)) begin
      item_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_req <= pending_reqs.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest prediction, predict accepted items
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_resps.size() == 0) begin
          $error("result with no item outstanding: status %0d", status_o);
          fail_count++;
        end else begin
          want = expected_resps.pop_front();
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
          if (opcode_out_o !== want.code) begin
            $error("opcode_out mismatch: expected %0h, actual %0h", want.code, opcode_out_o);
            fail_count++;
          end
          if (bucket_o !== want.bkt) begin
            $error("bucket mismatch: expected %0d, actual %0d", want.bkt, bucket_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_request(drv_req);
        expected_resps.push_back(want);
        status_tally[want.status]++;
        items_taken++;
        item_taken = 1'b1;
      end
      // Watchdog on cycles with no handshake in either direction
      if (result_valid_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no item or result for %0d cycles", WatchdogLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_item(logic cmd, logic [moht_pkg::KeyW-1:0] mnem,
                            logic [moht_pkg::CodeW-1:0] code);
    req_t rq;
    rq.cmd  = cmd;
    rq.mnem = mnem;
    rq.code = code;
    pending_reqs.push_back(rq);
  endtask

  // Mostly keys from a growing pool, some with junk after the NUL, plus raw noise
  task automatic queue_random_items(int count);
    logic [moht_pkg::KeyW-1:0] mnem;
    logic                      past_nul;
    int                        pick;
    int                        len;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        mnem = {$urandom, $urandom};
      end else begin
        if (key_pool.size() == 0 || pick < 20) begin
          len  = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
          mnem = '0;
          for (int i = 0; i < len; i++)
            mnem[moht_pkg::KeyW-1-8*i -: 8] = ($urandom_range(99) < 70) ?
                                              8'($urandom_range(8'h5A, 8'h41)) :
                                              8'($urandom_range(255, 1));
          key_pool.push_back(mnem);
        end else begin
          mnem = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        if ($urandom_range(1)) begin
          past_nul = 1'b0;
          for (int i = 0; i < 8; i++) begin
            if (past_nul) mnem[moht_pkg::KeyW-1-8*i -: 8] = 8'($urandom);
            else if (mnem[moht_pkg::KeyW-1-8*i -: 8] == 8'h00) past_nul = 1'b1;
          end
        end
      end
      queue_item(1'($urandom_range(1)), mnem, 8'($urandom));
    end
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_for_drain();
    while (pending_reqs.size() > 0 || start || expected_resps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    foreach (tbl_fill[b]) tbl_fill[b] = 0;
    foreach (status_tally[s]) status_tally[s] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 18;
    // Empty key, with and without junk after the NUL
    queue_item(moht_pkg::CmdLookup, 64'h0, 8'h00);
    queue_item(moht_pkg::CmdInsert, 64'h0, 8'hFF);
    queue_item(moht_pkg::CmdLookup, {8'h00, 56'hFF_FFFF_FFFF_FFFF}, 8'h00);
    queue_item(moht_pkg::CmdInsert, {8'h00, 56'h12_3456_789A_BCDE}, 8'h11);
    // Fill one bucket, overflow it, then hit a duplicate inside the full bucket
    queue_item(moht_pkg::CmdInsert, {"A", 56'h0}, 8'h01);
    queue_item(moht_pkg::CmdInsert, {"U", 56'h0}, 8'h02);
    queue_item(moht_pkg::CmdInsert, {"i", 56'h0}, 8'h03);
    queue_item(moht_pkg::CmdInsert, {"}", 56'h0}, 8'h04);
    queue_item(moht_pkg::CmdInsert, {8'h91, 56'h0}, 8'h05);
    queue_item(moht_pkg::CmdInsert, {"A", 56'h0}, 8'h77);
    queue_item(moht_pkg::CmdLookup, {8'h91, 56'h0}, 8'h00);
    queue_item(moht_pkg::CmdLookup, {"}", 8'h00, 48'hDEAD_BEEF_CAFE}, 8'h00);
    // All-ones key, full-length key, ordinary mnemonics, high-bit characters
    queue_item(moht_pkg::CmdInsert, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    queue_item(moht_pkg::CmdLookup, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    queue_item(moht_pkg::CmdInsert, "ABCDEFGH", 8'h5A);
    queue_item(moht_pkg::CmdLookup, "ABCDEFGH", 8'h00);
    queue_item(moht_pkg::CmdInsert, {"LDA", 8'h00, 32'hFFFF_FFFF}, 8'h00);
    queue_item(moht_pkg::CmdLookup, {"LDA", 40'h0}, 8'h00);
    queue_item(moht_pkg::CmdLookup, {"STA", 40'h0}, 8'h00);
    queue_item(moht_pkg::CmdInsert, {8'h80, 8'h7F, 48'h0}, 8'hA5);
    queue_item(moht_pkg::CmdLookup, {8'h80, 8'h7F, 8'h00, 40'hFF_FFFF_FFFF}, 8'h00);
    wait_for_drain();

    queue_random_items(530);
    wait_for_drain();
    send_idle_pct = 53;
    queue_random_items(535);
    wait_for_drain();
    send_idle_pct = 0;
    queue_random_items(535);
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (expected_resps.size() != 0) begin
      $error("%0d results never arrived", expected_resps.size());
      fail_count++;
    end
    $display("Ran %0d insert/lookup items with sender idling at 18%%, 53%% and 0%%.",
             items_taken);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d bucket full, %0d hit, %0d miss.",
             status_tally[moht_pkg::StInserted], status_tally[moht_pkg::StDuplicate],
             status_tally[moht_pkg::StFull], status_tally[moht_pkg::StHit],
             status_tally[moht_pkg::StMiss]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
